FILE: hdl/sbmt_pkg.sv
// Shared types and constants for the segment batch mask table.
`timescale 1ns / 1ps
`default_nettype none
package sbmt_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned BATCH_W    = 6;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned SPR_W      = 6;
  localparam int unsigned SCNT_W     = 9;
  localparam int unsigned BCNT_W     = 7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ACCUM = 2'd2,
    OP_QUERY = 2'd3
  } sbmt_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEG_SHIFT   = 3'd0,
    CFG_SEG_PER_ROW = 3'd1,
    CFG_CELL_RANGE  = 3'd2,
    CFG_SLOT_COUNT  = 3'd3,
    CFG_BATCH_COUNT = 3'd4
  } sbmt_cfg_e;

  typedef struct packed {
    logic cap;
    logic sweep;
    logic sweep_slots;
    logic slot_wr;
    logic prod;
    logic sum;
    logic seg_rd;
    logic acc_wr;
    logic scan_ld;
    logic emit;
  } sbmt_cmd_t;

  typedef struct packed {
    sbmt_op_e op;
    logic     sweep_last;
    logic     sweep_all_last;
    logic     out_free;
    logic     scan_last;
  } sbmt_sts_t;

endpackage
`default_nettype wire

FILE: hdl/segment_batch_mask_table_core.sv
// Segment batch mask table: top level joining controller and datapath.
// Input channel: in_valid_i/in_stall_o with one port per field. A transfer
// carries one operation: clear, load slot, accumulate cell or query segment.
// Output channel: out_valid_o/out_stall_i; only queries produce transfers,
// one per set batch bit in rising order with last_o on the final one, or a
// single miss transfer.
// Throughput: one item at a time. Load slot writes the slot table; accumulate
// steps through index multiply, index add and bound check, segment read and
// read-modify-write. A query runs the same steps up to the segment read, then
// issues one result per cycle while the output register is free; the next
// item is taken after the last result enters the output register. Clear
// sweeps the segment memory one entry a cycle.
// Reset: config registers return to their defaults and a clearing pass over
// max(SEGMENT_ENTRIES, SLOT_ENTRIES) entries runs before the first input
// transfer; config writes are taken during it.
// A stalled output holds its result; the scan waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module segment_batch_mask_table_core import sbmt_pkg::*; #(
  parameter int unsigned SEGMENT_ENTRIES = 1024,
  parameter int unsigned SLOT_ENTRIES    = 256,
  parameter int unsigned MAX_BATCHES     = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            operation_i,
  input  wire logic [COORD_W-1:0]    cell_x_i,
  input  wire logic [COORD_W-1:0]    cell_z_i,
  input  wire logic [SLOT_W-1:0]     texture_slot_i,
  input  wire logic [BATCH_W-1:0]    slot_batch_i,
  input  wire logic                  slot_valid_i,
  input  wire logic                  cell_water_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [BATCH_W-1:0]         batch_index_o,
  output logic                       batch_hit_o,
  output logic                       segment_found_o,
  output logic                       segment_has_water_o,
  output logic                       last_o
);

  sbmt_cmd_t cmd;
  sbmt_sts_t sts;

  sbmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbmt_dp #(
    .SEGMENT_ENTRIES(SEGMENT_ENTRIES),
    .SLOT_ENTRIES   (SLOT_ENTRIES),
    .MAX_BATCHES    (MAX_BATCHES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .cell_x_i           (cell_x_i),
    .cell_z_i           (cell_z_i),
    .texture_slot_i     (texture_slot_i),
    .slot_batch_i       (slot_batch_i),
    .slot_valid_i       (slot_valid_i),
    .cell_water_i       (cell_water_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .batch_index_o      (batch_index_o),
    .batch_hit_o        (batch_hit_o),
    .segment_found_o    (segment_found_o),
    .segment_has_water_o(segment_has_water_o),
    .last_o             (last_o)
  );

  // a miss is always the only result of its query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !batch_hit_o |-> last_o)
    else $error("miss result without last");

  // a segment outside the table reports neither batch nor water
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !segment_found_o |-> !batch_hit_o && !segment_has_water_o)
    else $error("result for missing segment carries hit or water");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second input transfer while item in flight");

  // results are only issued while the output register can take them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result issued into a held output register");

endmodule
`default_nettype wire

FILE: hdl/sbmt_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sbmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sbmt_ctrl.sv
// Control state machine: sequences sweeps, slot loads, accumulates and queries.
`timescale 1ns / 1ps
`default_nettype none
module sbmt_ctrl import sbmt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] operation_i,
  input  wire sbmt_sts_t  sts_i,
  output sbmt_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_LOAD,
    S_PROD,
    S_SUM,
    S_READ,
    S_UPD,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep       = 1'b1;
        cmd_o.sweep_slots = 1'b1;
        if (sts_i.sweep_all_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          case (sbmt_op_e'(operation_i))
            OP_CLEAR: state_d = S_CLEAR;
            OP_LOAD:  state_d = S_LOAD;
            default:  state_d = S_PROD;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_LOAD: begin
        cmd_o.slot_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_READ;
      end
      S_READ: begin
        cmd_o.seg_rd = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        if (sts_i.op == OP_ACCUM) begin
          cmd_o.acc_wr = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.scan_ld = 1'b1;
          state_d       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.scan_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sbmt_dp.sv
// Datapath: config registers, index math, slot and segment memories, result scan.
`timescale 1ns / 1ps
`default_nettype none
module sbmt_dp import sbmt_pkg::*; #(
  parameter int unsigned SEGMENT_ENTRIES = 1024,
  parameter int unsigned SLOT_ENTRIES    = 256,
  parameter int unsigned MAX_BATCHES     = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [1:0]            operation_i,
  input  wire logic [COORD_W-1:0]    cell_x_i,
  input  wire logic [COORD_W-1:0]    cell_z_i,
  input  wire logic [SLOT_W-1:0]     texture_slot_i,
  input  wire logic [BATCH_W-1:0]    slot_batch_i,
  input  wire logic                  slot_valid_i,
  input  wire logic                  cell_water_i,
  input  wire sbmt_cmd_t             cmd_i,
  output sbmt_sts_t                  sts_o,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic [BATCH_W-1:0]         batch_index_o,
  output logic                       batch_hit_o,
  output logic                       segment_found_o,
  output logic                       segment_has_water_o,
  output logic                       last_o
);

  localparam int unsigned SEG_AW  = (SEGMENT_ENTRIES > 1) ? $clog2(SEGMENT_ENTRIES) : 1;
  localparam int unsigned SLOT_AW = (SLOT_ENTRIES > 1) ? $clog2(SLOT_ENTRIES) : 1;
  localparam int unsigned SWP_N   = (SEGMENT_ENTRIES > SLOT_ENTRIES) ? SEGMENT_ENTRIES
                                                                     : SLOT_ENTRIES;
  localparam int unsigned CNT_W   = $clog2(SWP_N) + 1;
  localparam int unsigned MB      = MAX_BATCHES;
  localparam int unsigned SLOT_DW = BATCH_W + 1;
  localparam int unsigned PROD_W  = COORD_W + SPR_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned SQ_W    = 2 * SPR_W;

  // config registers
  logic [SHIFT_W-1:0] shift_q;
  logic [SPR_W-1:0]   spr_q;
  logic [COORD_W-1:0] crange_q;
  logic [SCNT_W-1:0]  scnt_q;
  logic [BCNT_W-1:0]  bcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= SHIFT_W'(3);
      spr_q    <= SPR_W'(32);
      crange_q <= COORD_W'(256);
      scnt_q   <= '0;
      bcnt_q   <= BCNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEG_SHIFT:   shift_q  <= cfg_data_i[SHIFT_W-1:0];
        CFG_SEG_PER_ROW: spr_q    <= cfg_data_i[SPR_W-1:0];
        CFG_CELL_RANGE:  crange_q <= cfg_data_i[COORD_W-1:0];
        CFG_SLOT_COUNT:  scnt_q   <= cfg_data_i[SCNT_W-1:0];
        CFG_BATCH_COUNT: bcnt_q   <= cfg_data_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  sbmt_op_e           op_q;
  logic [COORD_W-1:0] x_q, z_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [BATCH_W-1:0] sbatch_q;
  logic               svalid_q, cwater_q;
  logic [PROD_W-1:0]  prod_q;
  logic [SQ_W-1:0]    sq_q;
  logic               cell_ok_q;
  logic [SEG_AW-1:0]  idx_q;
  logic               seg_ok_q;
  logic [SUM_W-1:0]   sum;
  logic [COORD_W-1:0] xs, zs;

  assign xs  = x_q >> shift_q;
  assign zs  = z_q >> shift_q;
  assign sum = SUM_W'(prod_q) + SUM_W'(xs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q     <= sbmt_op_e'(operation_i);
      x_q      <= cell_x_i;
      z_q      <= cell_z_i;
      slot_q   <= texture_slot_i;
      sbatch_q <= slot_batch_i;
      svalid_q <= slot_valid_i;
      cwater_q <= cell_water_i;
    end
    if (cmd_i.prod) begin
      prod_q    <= {{SPR_W{1'b0}}, zs} * {{COORD_W{1'b0}}, spr_q};
      sq_q      <= {{SPR_W{1'b0}}, spr_q} * {{SPR_W{1'b0}}, spr_q};
      cell_ok_q <= (x_q < crange_q) && (z_q < crange_q);
    end
    if (cmd_i.sum) begin
      idx_q    <= SEG_AW'(sum);
      seg_ok_q <= (sum < SUM_W'(sq_q)) && (sum < SUM_W'(SEGMENT_ENTRIES));
    end
  end

  // clearing sweep
  logic [CNT_W-1:0] cnt_q;
  logic             sweep_last, sweep_all_last;

  assign sweep_last     = cnt_q == CNT_W'(SEGMENT_ENTRIES - 1);
  assign sweep_all_last = cnt_q == CNT_W'(SWP_N - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      cnt_q <= (cmd_i.sweep_slots ? sweep_all_last : sweep_last) ? '0
                                                                 : cnt_q + CNT_W'(1);
    end
  end

  // slot table
  logic               slot_ok;
  logic [SLOT_AW-1:0] slot_addr;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [SLOT_DW-1:0] slot_wdata, slot_rd;

  assign slot_ok    = ({1'b0, slot_q} < scnt_q) && (13'(slot_q) < 13'(SLOT_ENTRIES));
  assign slot_addr  = SLOT_AW'(slot_q);
  assign slot_we    = (cmd_i.sweep && cmd_i.sweep_slots && (cnt_q < CNT_W'(SLOT_ENTRIES)))
                   || (cmd_i.slot_wr && slot_ok);
  assign slot_waddr = cmd_i.sweep ? cnt_q[SLOT_AW-1:0] : slot_addr;
  assign slot_wdata = cmd_i.sweep ? '0 : {svalid_q, sbatch_q};

  sbmt_ram #(
    .WIDTH(SLOT_DW),
    .DEPTH(SLOT_ENTRIES)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .re_i   (cmd_i.prod && slot_ok),
    .raddr_i(slot_addr),
    .rdata_o(slot_rd)
  );

  // segment masks and water flags, {water, mask}
  logic              seg_we;
  logic [SEG_AW-1:0] seg_waddr;
  logic [MB:0]       seg_wdata, seg_rd;
  logic [MB-1:0]     bit_sel, lim;

  always_comb begin
    for (int i = 0; i < MB; i++) begin
      bit_sel[i] = slot_ok && slot_rd[BATCH_W] && (slot_rd[BATCH_W-1:0] == BATCH_W'(i));
      lim[i]     = bcnt_q > BCNT_W'(i);
    end
  end

  assign seg_we    = (cmd_i.sweep && (cnt_q < CNT_W'(SEGMENT_ENTRIES)))
                  || (cmd_i.acc_wr && seg_ok_q && cell_ok_q);
  assign seg_waddr = cmd_i.sweep ? cnt_q[SEG_AW-1:0] : idx_q;
  assign seg_wdata = cmd_i.sweep ? '0
                                 : {seg_rd[MB] | cwater_q, seg_rd[MB-1:0] | bit_sel};

  sbmt_ram #(
    .WIDTH(MB + 1),
    .DEPTH(SEGMENT_ENTRIES)
  ) u_seg_ram (
    .clk_i  (clk_i),
    .we_i   (seg_we),
    .waddr_i(seg_waddr),
    .wdata_i(seg_wdata),
    .re_i   (cmd_i.seg_rd && seg_ok_q),
    .raddr_i(idx_q),
    .rdata_o(seg_rd)
  );

  // result scan, lowest set bit first
  logic [MB-1:0]      scan_q, iso, rest;
  logic               sfound_q, swater_q;
  logic [BATCH_W-1:0] bidx;

  assign iso  = scan_q & (~scan_q + MB'(1));
  assign rest = scan_q & (scan_q - MB'(1));

  always_comb begin
    bidx = '0;
    for (int i = 0; i < MB; i++) begin
      if (iso[i]) bidx = bidx | BATCH_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_ld) begin
      scan_q   <= seg_ok_q ? (seg_rd[MB-1:0] & lim) : '0;
      sfound_q <= seg_ok_q;
      swater_q <= seg_ok_q && seg_rd[MB];
    end else if (cmd_i.emit) begin
      scan_q <= rest;
    end
  end

  // output register
  logic               out_valid_q;
  logic [BATCH_W-1:0] out_bidx_q;
  logic               out_hit_q, out_found_q, out_water_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_bidx_q  <= bidx;
      out_hit_q   <= |scan_q;
      out_found_q <= sfound_q;
      out_water_q <= swater_q;
      out_last_q  <= rest == '0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign batch_index_o       = out_bidx_q;
  assign batch_hit_o         = out_hit_q;
  assign segment_found_o     = out_found_q;
  assign segment_has_water_o = out_water_q;
  assign last_o              = out_last_q;

  assign sts_o.op             = op_q;
  assign sts_o.sweep_last     = sweep_last;
  assign sts_o.sweep_all_last = sweep_all_last;
  assign sts_o.out_free       = !out_valid_q || !out_stall_i;
  assign sts_o.scan_last      = rest == '0;

endmodule
`default_nettype wire

FILE: tb/tb_segment_batch_mask_table_core.sv
// Self-checking testbench for the segment batch mask table core.
`timescale 1ns / 1ps
module tb_segment_batch_mask_table_core;
  import sbmt_pkg::*;

  localparam int unsigned SEG_ENTRIES  = 1024;
  localparam int unsigned SLOT_ENTRIES = 256;
  localparam int unsigned BATCH_LIMIT  = 64;
  localparam int unsigned WATCHDOG     = 20000;

  typedef struct packed {
    sbmt_op_e             op;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   z;
    logic [SLOT_W-1:0]    slot;
    logic [BATCH_W-1:0]   batch;
    logic                 slot_ok;
    logic                 wet;
  } terrain_cmd_t;

  typedef struct packed {
    logic [BATCH_W-1:0] batch_index;
    logic               hit;
    logic               found;
    logic               water;
    logic               last;
  } draw_t;

  class batch_mask_tracker;
    logic [SHIFT_W-1:0]    seg_shift;
    logic [SPR_W-1:0]      seg_per_row;
    logic [COORD_W-1:0]    map_cells;
    logic [SCNT_W-1:0]     slots_used;
    logic [BCNT_W-1:0]     batches;
    logic [6:0]            slot_map [SLOT_ENTRIES];
    logic [63:0]           seg_mask [SEG_ENTRIES];
    logic                  seg_wet  [SEG_ENTRIES];
    draw_t                 pending_draws[$];
    int unsigned           mismatches;
    int unsigned           draws_checked;

    function new();
      seg_shift   = 3;
      seg_per_row = 32;
      map_cells   = 256;
      slots_used  = 0;
      batches     = 1;
      foreach (slot_map[i]) slot_map[i] = '0;
      wipe_segments();
      mismatches    = 0;
      draws_checked = 0;
    endfunction

    function void wipe_segments();
      foreach (seg_mask[i]) begin
        seg_mask[i] = '0;
        seg_wet[i]  = 1'b0;
      end
    endfunction

    function void set_reg(sbmt_cfg_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_SEG_SHIFT:   seg_shift   = d[SHIFT_W-1:0];
        CFG_SEG_PER_ROW: seg_per_row = d[SPR_W-1:0];
        CFG_CELL_RANGE:  map_cells   = d[COORD_W-1:0];
        CFG_SLOT_COUNT:  slots_used  = d[SCNT_W-1:0];
        CFG_BATCH_COUNT: batches     = d[BCNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Segment index of (x, z) in idx; returns 0 when the index lies outside the table.
    function bit find_segment(logic [COORD_W-1:0] x, logic [COORD_W-1:0] z,
                              output int unsigned idx);
      int unsigned spr;
      int unsigned lim;
      int unsigned si;
      spr = seg_per_row;
      lim = spr * spr;
      if (lim > SEG_ENTRIES) lim = SEG_ENTRIES;
      si  = ((int'(z) >> seg_shift) * spr) + (int'(x) >> seg_shift);
      idx = si;
      return si < lim;
    endfunction

    function bit slot_live(logic [SLOT_W-1:0] s);
      return (s < slots_used) && (s < SLOT_ENTRIES);
    endfunction

    function void note_transfer(terrain_cmd_t c);
      int unsigned si;
      int unsigned lim;
      bit          hit_any;
      draw_t       d;
      case (c.op)
        OP_CLEAR: wipe_segments();
        OP_LOAD: begin
          if (slot_live(c.slot)) slot_map[c.slot] = {c.slot_ok, c.batch};
        end
        OP_ACCUM: begin
          if (c.x < map_cells && c.z < map_cells && find_segment(c.x, c.z, si)) begin
            if (c.wet) seg_wet[si] = 1'b1;
            if (slot_live(c.slot) && slot_map[c.slot][6])
              seg_mask[si][slot_map[c.slot][5:0]] = 1'b1;
          end
        end
        default: begin
          if (!find_segment(c.x, c.z, si)) begin
            d = '{batch_index: '0, hit: 1'b0, found: 1'b0, water: 1'b0, last: 1'b1};
            pending_draws.insert(pending_draws.size(), d);
          end else begin
            lim = (batches > BATCH_LIMIT) ? BATCH_LIMIT : batches;
            hit_any = 1'b0;
            for (int unsigned b = 0; b < lim; b++) begin
              if (seg_mask[si][b]) begin
                d = '{batch_index: b[BATCH_W-1:0], hit: 1'b1, found: 1'b1,
                      water: seg_wet[si], last: 1'b0};
                pending_draws.insert(pending_draws.size(), d);
                hit_any = 1'b1;
              end
            end
            if (hit_any) begin
              pending_draws[pending_draws.size()-1].last = 1'b1;
            end else begin
              d = '{batch_index: '0, hit: 1'b0, found: 1'b1,
                    water: seg_wet[si], last: 1'b1};
              pending_draws.insert(pending_draws.size(), d);
            end
          end
        end
      endcase
    endfunction

    function void check_draw(draw_t got);
      draw_t want;
      draws_checked++;
      if (pending_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: idx=%0d hit=%b found=%b water=%b last=%b",
                   $realtime, got.batch_index, got.hit, got.found, got.water, got.last);
        return;
      end
      want = pending_draws.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: expected idx=%0d hit=%b found=%b water=%b last=%b, %s",
                   $realtime, want.batch_index, want.hit, want.found, want.water,
                   want.last,
                   $sformatf("got idx=%0d hit=%b found=%b water=%b last=%b",
                             got.batch_index, got.hit, got.found, got.water, got.last));
      end
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            operation_i    = '0;
  logic [COORD_W-1:0]    cell_x_i       = '0;
  logic [COORD_W-1:0]    cell_z_i       = '0;
  logic [SLOT_W-1:0]     texture_slot_i = '0;
  logic [BATCH_W-1:0]    slot_batch_i   = '0;
  logic                  slot_valid_i   = 1'b0;
  logic                  cell_water_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [BATCH_W-1:0]    batch_index_o;
  logic                  batch_hit_o;
  logic                  segment_found_o;
  logic                  segment_has_water_o;
  logic                  last_o;

  batch_mask_tracker tracker = new();

  int unsigned stim_shift = 3;
  int unsigned stim_range = 256;
  int unsigned stim_slots = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 1;
  int unsigned quiet_cycles = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          stall_run = 0;
  logic        stall_next;
  draw_t       seen;

  segment_batch_mask_table_core #(
    .SEGMENT_ENTRIES(SEG_ENTRIES),
    .SLOT_ENTRIES   (SLOT_ENTRIES),
    .MAX_BATCHES    (BATCH_LIMIT)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .cell_x_i           (cell_x_i),
    .cell_z_i           (cell_z_i),
    .texture_slot_i     (texture_slot_i),
    .slot_batch_i       (slot_batch_i),
    .slot_valid_i       (slot_valid_i),
    .cell_water_i       (cell_water_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .batch_index_o      (batch_index_o),
    .batch_hit_o        (batch_hit_o),
    .segment_found_o    (segment_found_o),
    .segment_has_water_o(segment_has_water_o),
    .last_o             (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Output backpressure: modes of free flow, light, heavy and periodic stall.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 80);
    end
    mode_left--;
    case (stall_mode)
      0:       stall_next = 1'b0;
      1:       stall_next = ($urandom_range(0, 3) == 0);
      2:       stall_next = ($urandom_range(0, 3) != 0);
      default: stall_next = mode_left[1];
    endcase
    if (stall_run >= 6) stall_next = 1'b0;
    stall_run   = stall_next ? stall_run + 1 : 0;
    out_stall_i = stall_next;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen = {batch_index_o, batch_hit_o, segment_found_o, segment_has_water_o, last_o};
        tracker.check_draw(seen);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic terrain_cmd_t cmd(sbmt_op_e op, int unsigned x, int unsigned z,
                                       int unsigned slot, int unsigned batch,
                                       bit ok, bit wet);
    terrain_cmd_t c;
    c.op      = op;
    c.x       = x[COORD_W-1:0];
    c.z       = z[COORD_W-1:0];
    c.slot    = slot[SLOT_W-1:0];
    c.batch   = batch[BATCH_W-1:0];
    c.slot_ok = ok;
    c.wet     = wet;
    return c;
  endfunction

  // Mostly a few segments near the origin so queries find filled masks.
  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned span;
    span = stim_range;
    if (span == 0) return COORD_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 2) != 0 && (3 << stim_shift) < span) span = 3 << stim_shift;
    return COORD_W'($urandom_range(0, span - 1));
  endfunction

  function automatic terrain_cmd_t random_item();
    terrain_cmd_t c;
    int unsigned  pick;
    int unsigned  slot_span;
    c = cmd(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095),
            $urandom_range(0, 255), $urandom_range(0, 63),
            $urandom_range(0, 1), $urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 4)       c.op = OP_CLEAR;
    else if (pick < 30) c.op = OP_LOAD;
    else if (pick < 66) c.op = OP_ACCUM;
    else                c.op = OP_QUERY;
    if ($urandom_range(0, 9) != 0) begin
      slot_span = (stim_slots > SLOT_ENTRIES) ? SLOT_ENTRIES : stim_slots;
      if (slot_span != 0) c.slot = SLOT_W'($urandom_range(0, slot_span - 1));
      c.x = pick_coord();
      c.z = pick_coord();
      if (c.op == OP_LOAD) c.slot_ok = ($urandom_range(0, 5) != 0);
    end
    return c;
  endfunction

  task automatic send(input terrain_cmd_t c);
    @(negedge clk_i);
    in_valid_i     = 1'b1;
    operation_i    = c.op;
    cell_x_i       = c.x;
    cell_z_i       = c.z;
    texture_slot_i = c.slot;
    slot_batch_i   = c.batch;
    slot_valid_i   = c.slot_ok;
    cell_water_i   = c.wet;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_transfer(c);
    items_sent++;
  endtask

  task automatic wait_results();
    while (tracker.pending_draws.size() != 0) @(posedge clk_i);
  endtask

  // Idle the input, let every result arrive, then cover a full clear sweep.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_results();
    repeat (SEG_ENTRIES + 40) @(posedge clk_i);
  endtask

  task automatic write_reg(input sbmt_cfg_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    tracker.set_reg(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic write_config(input int unsigned shift, input int unsigned spr,
                              input int unsigned span, input int unsigned slots,
                              input int unsigned batches);
    write_reg(CFG_SEG_SHIFT, shift);
    write_reg(CFG_SEG_PER_ROW, spr);
    write_reg(CFG_CELL_RANGE, span);
    write_reg(CFG_SLOT_COUNT, slots);
    write_reg(CFG_BATCH_COUNT, batches);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    stim_shift = shift % 8;
    stim_range = span % 4096;
    stim_slots = slots % 512;
    settings_used++;
  endtask

  task automatic run_random(input int count);
    int burst;
    int gap;
    burst = $urandom_range(1, 30);
    repeat (count) begin
      send(random_item());
      burst--;
      if ($urandom_range(0, 19) == 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        wait_results();
      end else if (burst <= 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        gap = $urandom_range(1, 10);
        repeat (gap - 1) @(negedge clk_i);
        burst = $urandom_range(1, 30);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: no slots in use, one batch.
    send(cmd(OP_QUERY, 0, 0, 0, 0, 0, 0));
    send(cmd(OP_LOAD, 0, 0, 5, 9, 1, 0));
    send(cmd(OP_ACCUM, 0, 0, 5, 0, 0, 1));
    send(cmd(OP_QUERY, 7, 7, 0, 0, 0, 0));
    send(cmd(OP_QUERY, 4095, 4095, 255, 63, 1, 1));
    drain();

    write_config(3, 32, 256, 256, 64);
    send(cmd(OP_LOAD, 0, 0, 0, 0, 1, 0));
    send(cmd(OP_LOAD, 0, 0, 255, 63, 1, 0));
    send(cmd(OP_LOAD, 0, 0, 7, 33, 0, 0));
    send(cmd(OP_LOAD, 0, 0, 8, 5, 1, 0));
    send(cmd(OP_ACCUM, 0, 0, 0, 0, 0, 0));
    send(cmd(OP_ACCUM, 7, 7, 255, 0, 0, 0));
    send(cmd(OP_ACCUM, 3, 3, 8, 0, 0, 0));
    send(cmd(OP_ACCUM, 1, 1, 7, 0, 0, 1));
    send(cmd(OP_ACCUM, 255, 255, 8, 0, 0, 1));
    send(cmd(OP_ACCUM, 256, 0, 0, 0, 0, 1));
    send(cmd(OP_ACCUM, 0, 4095, 255, 0, 0, 1));
    send(cmd(OP_QUERY, 0, 0, 0, 0, 0, 0));
    send(cmd(OP_QUERY, 255, 255, 0, 0, 0, 0));
    send(cmd(OP_QUERY, 8, 0, 0, 0, 0, 0));
    send(cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send(cmd(OP_QUERY, 0, 0, 0, 0, 0, 0));
    drain();

    // Unit segments, two per row: column spill and the batch limit.
    write_config(0, 2, 4095, 256, 2);
    send(cmd(OP_ACCUM, 2, 0, 0, 0, 0, 0));
    send(cmd(OP_ACCUM, 1, 0, 8, 0, 0, 1));
    send(cmd(OP_QUERY, 0, 1, 0, 0, 0, 0));
    send(cmd(OP_QUERY, 1, 0, 0, 0, 0, 0));
    send(cmd(OP_QUERY, 4, 0, 0, 0, 0, 0));
    drain();

    write_config(6, 1, 64, 256, 64);
    run_random(20);
    drain();
    write_config(2, 32, 128, 16, 127);
    run_random(20);
    drain();
    write_config(7, 63, 4095, 511, 0);
    run_random(18);
    drain();
    write_config(0, 32, 32, 256, 33);
    run_random(20);
    drain();
    write_config(1, 0, 1, 3, 64);
    run_random(8);
    drain();
    repeat (2) begin
      write_config($urandom_range(0, 7), $urandom_range(1, 32), $urandom_range(1, 4095),
                   $urandom_range(0, 511), $urandom_range(0, 127));
      run_random(20);
      drain();
    end

    $display("run covered %0d input transfers under %0d register settings",
             items_sent, settings_used);
    $display("%0d query results checked, %0d mismatches, %0d results never seen",
             tracker.draws_checked, tracker.mismatches, tracker.pending_draws.size());
    if (tracker.mismatches == 0 && tracker.pending_draws.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
